>>> sv/cca_pkg.sv
// Shared types, widths and codes for the coupled alpha calculator.
package cca_pkg;

    // Default sizing
    localparam int SUBFLOW_COUNT_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF       = 4;

    // Field widths
    localparam int CWND_W    = 24;
    localparam int RTT_W     = 24;
    localparam int BACKOFF_W = 6;
    localparam int ALPHA_W   = 32;
    localparam int TOTAL_W   = 32;
    localparam int TERM_W    = 64;
    localparam int FLOOR_W   = 32;
    localparam int MUL_W     = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BACKOFF_LIMIT = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MIN_RTT       = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_FLOOR     = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SUM_FLOOR     = 4'd3;

    localparam logic [BACKOFF_W-1:0] BACKOFF_LIMIT_RST = 6'd4;
    localparam logic [RTT_W-1:0]     MIN_RTT_RST       = 24'd1;
    localparam logic [FLOOR_W-1:0]   MAX_FLOOR_RST     = 32'd1;
    localparam logic [FLOOR_W-1:0]   SUM_FLOOR_RST     = 32'd1;

    // Divider sizing: the alpha numerator is (total * max) << 56
    localparam int ALPHA_SHIFT = 56;
    localparam int TM_W        = TOTAL_W + TERM_W;
    localparam int SS_W        = 2 * TERM_W;
    localparam int DIV_NUM_W   = TM_W + ALPHA_SHIFT;
    localparam int DIV_DEN_W   = SS_W;
    localparam int DIV_Q_W     = TERM_W;
    localparam int DIV_STEP_W  = 8;
    localparam logic [DIV_STEP_W-1:0] RATE_STEPS  = 8'd64;
    localparam logic [DIV_STEP_W-1:0] ALPHA_STEPS = 8'd152;

    // Partial products of the final multiply sequence
    typedef logic [2:0] pp_idx_t;
    localparam pp_idx_t PP_TM_LO = 3'd0;
    localparam pp_idx_t PP_TM_HI = 3'd1;
    localparam pp_idx_t PP_SS_LL = 3'd2;
    localparam pp_idx_t PP_SS_LH = 3'd3;
    localparam pp_idx_t PP_SS_HL = 3'd4;
    localparam pp_idx_t PP_SS_HH = 3'd5;

    typedef enum logic {
        OP_SKIP,
        OP_ACCUM
    } op_t;

    // One classified record, front to back
    typedef struct packed {
        op_t               op;
        logic              start;
        logic              last;
        logic              abort;
        logic [CWND_W-1:0] cwnd;
        logic [RTT_W-1:0]  rtt;
    } entry_t;

    typedef struct packed {
        logic [BACKOFF_W-1:0] backoff_limit;
        logic [RTT_W-1:0]     min_rtt;
        logic [FLOOR_W-1:0]   max_floor;
        logic [FLOOR_W-1:0]   sum_floor;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIV_Q_W-1:0] quo;
        logic               over;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DISPATCH,
        B_SQ_MUL,
        B_RATE_GO,
        B_RATE_WAIT,
        B_TERM_GO,
        B_TERM_WAIT,
        B_UPDATE,
        B_CHECK,
        B_FIN_MUL,
        B_FIN_ACC,
        B_FIN_GO,
        B_FIN_WAIT,
        B_EMIT
    } back_state_t;

endpackage

>>> sv/cca_front.sv
// Front end: accepts subflow records, tracks round position and abort, classifies.
module cca_front #(
    parameter int SUBFLOW_COUNT_MAX = cca_pkg::SUBFLOW_COUNT_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [cca_pkg::CWND_W-1:0]     cwnd,
    input  logic [cca_pkg::RTT_W-1:0]      rtt_us,
    input  logic [cca_pkg::BACKOFF_W-1:0]  backoff,
    input  logic                           last,
    input  cca_pkg::cfg_t                  cfg,
    input  logic                           q_full,
    output logic                           push,
    output cca_pkg::entry_t                entry
);

    localparam int CNT_W = $clog2(SUBFLOW_COUNT_MAX + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             aborted_reg, aborted_next;
    logic             start;
    logic             ab_in;
    logic             counted;
    logic             ab_out;

    // Classification of the offered record
    always_comb
    begin
        start   = (cnt_reg == '0);
        ab_in   = start ? 1'b0 : aborted_reg;
        counted = (cnt_reg < CNT_W'(SUBFLOW_COUNT_MAX)) && !ab_in
                  && (backoff < cfg.backoff_limit);
        ab_out  = ab_in || (counted && (rtt_us < cfg.min_rtt));

        entry.op    = (counted && !ab_out) ? cca_pkg::OP_ACCUM : cca_pkg::OP_SKIP;
        entry.start = start;
        entry.last  = last;
        entry.abort = ab_out;
        entry.cwnd  = cwnd;
        entry.rtt   = rtt_us;

        push = in_valid && !q_full;

        cnt_next     = cnt_reg;
        aborted_next = aborted_reg;
        if (push)
        begin
            if (last)
            begin
                cnt_next     = '0;
                aborted_next = 1'b0;
            end
            else
            begin
                if (cnt_reg < CNT_W'(SUBFLOW_COUNT_MAX))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                aborted_next = ab_out;
            end
        end
    end

    // Round position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

>>> sv/cca_fifo.sv
// Short queue of classified records between front and back.
module cca_fifo #(
    parameter int DEPTH = cca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cca_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output cca_pkg::entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cca_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> sv/cca_div.sv
// Shared restoring divider, one quotient bit per cycle, with overflow sticky.
module cca_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cca_pkg::div_req_t req,
    output cca_pkg::div_rsp_t rsp
);

    localparam int NW = cca_pkg::DIV_NUM_W;
    localparam int DW = cca_pkg::DIV_DEN_W;
    localparam int QW = cca_pkg::DIV_Q_W;
    localparam int SW = cca_pkg::DIV_STEP_W;

    logic          busy_reg;
    logic [SW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic          over_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          ge;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, num_reg[NW-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        ge      = !diff[DW+1];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (cnt_reg == SW'(1)))
        begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            cnt_reg  <= req.steps;
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quo_reg  <= '0;
            over_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - SW'(1);
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            rem_reg  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg  <= {quo_reg[QW-2:0], ge};
            over_reg <= over_reg | quo_reg[QW-1];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.over = over_reg;

endmodule

>>> sv/cca_back.sv
// Back end: per-record rate and term, accumulation, final alpha and result register.
module cca_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cca_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  cca_pkg::entry_t               q_entry,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cca_pkg::ALPHA_W-1:0]   alpha,
    output logic                          updated
);

    localparam int TW = cca_pkg::TERM_W;
    localparam int MW = cca_pkg::MUL_W;
    localparam int AW = cca_pkg::ALPHA_W;
    localparam int NW = cca_pkg::DIV_NUM_W;
    localparam int DW = cca_pkg::DIV_DEN_W;

    cca_pkg::back_state_t state_reg, state_next;
    cca_pkg::entry_t      ent_reg, ent_next;
    cca_pkg::div_req_t    div_req;
    cca_pkg::div_rsp_t    div_rsp;
    cca_pkg::pp_idx_t     mul_idx_reg, mul_idx_next;

    logic [TW-1:0]                 max_reg, max_next;
    logic [TW-1:0]                 sum_reg, sum_next;
    logic [cca_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [TW-1:0]                 rate_reg, rate_next;
    logic [TW-1:0]                 term_reg, term_next;
    logic [AW-1:0]                 alpha_reg, alpha_next;
    logic                          upd_reg, upd_next;
    logic [2*MW-1:0]               pp_reg, pp_next;
    logic [cca_pkg::TM_W-1:0]      tm_acc_reg, tm_acc_next;
    logic [cca_pkg::SS_W-1:0]      ss_acc_reg, ss_acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic [AW-1:0]                 out_alpha_reg, out_alpha_next;
    logic                          out_upd_reg, out_upd_next;
    logic                          out_load;

    logic [MW-1:0]                 mul_a, mul_b;
    logic [2*MW-1:0]               mul_p;
    logic [TW:0]                   sum_wide;
    logic [cca_pkg::TOTAL_W:0]     total_wide;

    cca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared 32x32 multiplier, registered into pp_reg
    assign mul_p = mul_a * mul_b;

    assign sum_wide   = {1'b0, sum_reg} + {1'b0, rate_reg};
    assign total_wide = {1'b0, total_reg} + {1'b0, (cca_pkg::TOTAL_W)'(ent_reg.cwnd)};

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        mul_idx_next   = mul_idx_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        rate_next      = rate_reg;
        term_next      = term_reg;
        alpha_next     = alpha_reg;
        upd_next       = upd_reg;
        pp_next        = pp_reg;
        tm_acc_next    = tm_acc_reg;
        ss_acc_next    = ss_acc_reg;
        out_alpha_next = out_alpha_reg;
        out_upd_next   = out_upd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        q_pop          = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;

        case (state_reg)
            cca_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ent_next = q_entry;
                    if (q_entry.start)
                    begin
                        max_next   = TW'(cfg.max_floor);
                        sum_next   = '0;
                        total_next = '0;
                    end
                    state_next = cca_pkg::B_DISPATCH;
                end
            end

            cca_pkg::B_DISPATCH:
            begin
                if (ent_reg.op == cca_pkg::OP_ACCUM)
                begin
                    if (ent_reg.rtt == '0)
                    begin
                        // zero rtt: both quotients saturate
                        rate_next  = '1;
                        term_next  = '1;
                        state_next = cca_pkg::B_UPDATE;
                    end
                    else
                    begin
                        state_next = cca_pkg::B_SQ_MUL;
                    end
                end
                else
                begin
                    state_next = cca_pkg::B_CHECK;
                end
            end

            cca_pkg::B_SQ_MUL:
            begin
                mul_a      = MW'(ent_reg.rtt);
                mul_b      = MW'(ent_reg.rtt);
                pp_next    = mul_p;
                state_next = cca_pkg::B_RATE_GO;
            end

            cca_pkg::B_RATE_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = cca_pkg::RATE_STEPS;
                div_req.num   = {ent_reg.cwnd, {(NW - cca_pkg::CWND_W){1'b0}}};
                div_req.den   = DW'(ent_reg.rtt);
                state_next    = cca_pkg::B_RATE_WAIT;
            end

            cca_pkg::B_RATE_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    rate_next  = div_rsp.quo;
                    state_next = cca_pkg::B_TERM_GO;
                end
            end

            cca_pkg::B_TERM_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = cca_pkg::RATE_STEPS;
                div_req.num   = {ent_reg.cwnd, {(NW - cca_pkg::CWND_W){1'b0}}};
                div_req.den   = DW'(pp_reg[2*cca_pkg::RTT_W-1:0]);
                state_next    = cca_pkg::B_TERM_WAIT;
            end

            cca_pkg::B_TERM_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    term_next  = div_rsp.quo;
                    state_next = cca_pkg::B_UPDATE;
                end
            end

            cca_pkg::B_UPDATE:
            begin
                if (term_reg > max_reg)
                begin
                    max_next = term_reg;
                end
                sum_next   = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
                total_next = total_wide[cca_pkg::TOTAL_W] ? '1
                                                          : total_wide[cca_pkg::TOTAL_W-1:0];
                state_next = cca_pkg::B_CHECK;
            end

            cca_pkg::B_CHECK:
            begin
                if (!ent_reg.last)
                begin
                    state_next = cca_pkg::B_IDLE;
                end
                else if (ent_reg.abort || (sum_reg < TW'(cfg.sum_floor)))
                begin
                    upd_next   = 1'b0;
                    state_next = cca_pkg::B_EMIT;
                end
                else if (sum_reg == '0)
                begin
                    // empty denominator saturates
                    alpha_next = '1;
                    upd_next   = 1'b1;
                    state_next = cca_pkg::B_EMIT;
                end
                else
                begin
                    mul_idx_next = cca_pkg::PP_TM_LO;
                    tm_acc_next  = '0;
                    ss_acc_next  = '0;
                    state_next   = cca_pkg::B_FIN_MUL;
                end
            end

            cca_pkg::B_FIN_MUL:
            begin
                case (mul_idx_reg)
                    cca_pkg::PP_TM_LO:
                    begin
                        mul_a = total_reg;
                        mul_b = max_reg[MW-1:0];
                    end
                    cca_pkg::PP_TM_HI:
                    begin
                        mul_a = total_reg;
                        mul_b = max_reg[TW-1:MW];
                    end
                    cca_pkg::PP_SS_LL:
                    begin
                        mul_a = sum_reg[MW-1:0];
                        mul_b = sum_reg[MW-1:0];
                    end
                    cca_pkg::PP_SS_LH:
                    begin
                        mul_a = sum_reg[MW-1:0];
                        mul_b = sum_reg[TW-1:MW];
                    end
                    cca_pkg::PP_SS_HL:
                    begin
                        mul_a = sum_reg[TW-1:MW];
                        mul_b = sum_reg[MW-1:0];
                    end
                    cca_pkg::PP_SS_HH:
                    begin
                        mul_a = sum_reg[TW-1:MW];
                        mul_b = sum_reg[TW-1:MW];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                pp_next    = mul_p;
                state_next = cca_pkg::B_FIN_ACC;
            end

            cca_pkg::B_FIN_ACC:
            begin
                case (mul_idx_reg)
                    cca_pkg::PP_TM_LO:
                        tm_acc_next = tm_acc_reg + {{MW{1'b0}}, pp_reg};
                    cca_pkg::PP_TM_HI:
                        tm_acc_next = tm_acc_reg + {pp_reg, {MW{1'b0}}};
                    cca_pkg::PP_SS_LL:
                        ss_acc_next = ss_acc_reg + {{(2*MW){1'b0}}, pp_reg};
                    cca_pkg::PP_SS_LH,
                    cca_pkg::PP_SS_HL:
                        ss_acc_next = ss_acc_reg + {{MW{1'b0}}, pp_reg, {MW{1'b0}}};
                    cca_pkg::PP_SS_HH:
                        ss_acc_next = ss_acc_reg + {pp_reg, {(2*MW){1'b0}}};
                    default:
                        ss_acc_next = ss_acc_reg;
                endcase
                if (mul_idx_reg == cca_pkg::PP_SS_HH)
                begin
                    state_next = cca_pkg::B_FIN_GO;
                end
                else
                begin
                    mul_idx_next = mul_idx_reg + 3'd1;
                    state_next   = cca_pkg::B_FIN_MUL;
                end
            end

            cca_pkg::B_FIN_GO:
            begin
                div_req.start = 1'b1;
                div_req.steps = cca_pkg::ALPHA_STEPS;
                div_req.num   = {tm_acc_reg, {cca_pkg::ALPHA_SHIFT{1'b0}}};
                div_req.den   = ss_acc_reg;
                state_next    = cca_pkg::B_FIN_WAIT;
            end

            cca_pkg::B_FIN_WAIT:
            begin
                if (!div_rsp.busy)
                begin
                    // quotient beyond 32 bits saturates
                    alpha_next = (div_rsp.over || (div_rsp.quo[TW-1:AW] != '0))
                                 ? '1 : div_rsp.quo[AW-1:0];
                    upd_next   = 1'b1;
                    state_next = cca_pkg::B_EMIT;
                end
            end

            cca_pkg::B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_alpha_next = alpha_reg;
                    out_upd_next   = upd_reg;
                    state_next     = cca_pkg::B_IDLE;
                end
            end

            default:
            begin
                state_next = cca_pkg::B_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cca_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            alpha_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            alpha_reg     <= alpha_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ent_reg       <= ent_next;
        mul_idx_reg   <= mul_idx_next;
        max_reg       <= max_next;
        sum_reg       <= sum_next;
        total_reg     <= total_next;
        rate_reg      <= rate_next;
        term_reg      <= term_next;
        upd_reg       <= upd_next;
        pp_reg        <= pp_next;
        tm_acc_reg    <= tm_acc_next;
        ss_acc_reg    <= ss_acc_next;
        out_alpha_reg <= out_alpha_next;
        out_upd_reg   <= out_upd_next;
    end

    assign out_valid = out_valid_reg;
    assign alpha     = out_alpha_reg;
    assign updated   = out_upd_reg;

`ifndef SYNTHESIS
    // Divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Divider only runs while the sequencer waits on it
    a_div_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> (state_reg == cca_pkg::B_RATE_WAIT ||
                          state_reg == cca_pkg::B_TERM_WAIT ||
                          state_reg == cca_pkg::B_FIN_WAIT))
        else $error("divider busy outside a wait state");

    // A result is produced only for the closing record of a round
    a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ent_reg.last)
        else $error("result loaded for a record that does not close the round");

    // A round without update hands out the stored alpha unchanged
    a_keep_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !upd_reg) |-> $stable(alpha_reg))
        else $error("alpha changed in a round without update");
`endif

endmodule

>>> sv/coupled_cc_alpha_calc.sv
// Top level of the coupled congestion control alpha calculator.
//
// One subflow record is taken per transfer on the input channel and one result
// per round (on the record with last set) is given on the output channel. The
// front end accepts a record in any cycle while its queue (4 entries by default)
// has room and classifies it at once; the back end then works through the queue.
// A skipped or aborting record passes the back end through dispatch and check
// only, and a counted record with zero rtt, whose quotients saturate without
// the divider, adds an update step. Any other counted record squares its rtt and
// then waits on the shared bit-serial divider, which runs two 64-step divisions
// (cwnd/rtt and cwnd/rtt^2) one quotient bit per cycle. A closing record loads
// the output register; if it recomputes alpha it first forms the six 32x32
// partial products of total*max and sum^2 on the shared multiplier, then starts
// the 152-step alpha division. The result sits in an output register, so the
// back end goes on with the next queued record unless a second result is ready
// while the first is still stalled. There is no clearing pass after reset.
module coupled_cc_alpha_calc #(
    parameter int SUBFLOW_COUNT_MAX = cca_pkg::SUBFLOW_COUNT_MAX_DEF,
    parameter int QUEUE_DEPTH       = cca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [cca_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cca_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // subflow records
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [cca_pkg::CWND_W-1:0]       cwnd,
    input  logic [cca_pkg::RTT_W-1:0]        rtt_us,
    input  logic [cca_pkg::BACKOFF_W-1:0]    backoff,
    input  logic                             last,
    // round results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cca_pkg::ALPHA_W-1:0]      alpha,
    output logic                             updated
);

    cca_pkg::cfg_t   cfg_reg;
    cca_pkg::entry_t push_entry;
    cca_pkg::entry_t pop_entry;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backoff_limit <= cca_pkg::BACKOFF_LIMIT_RST;
            cfg_reg.min_rtt       <= cca_pkg::MIN_RTT_RST;
            cfg_reg.max_floor     <= cca_pkg::MAX_FLOOR_RST;
            cfg_reg.sum_floor     <= cca_pkg::SUM_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                cca_pkg::CFG_IDX_BACKOFF_LIMIT:
                    cfg_reg.backoff_limit <= cfg_wdata[cca_pkg::BACKOFF_W-1:0];
                cca_pkg::CFG_IDX_MIN_RTT:
                    cfg_reg.min_rtt <= cfg_wdata[cca_pkg::RTT_W-1:0];
                cca_pkg::CFG_IDX_MAX_FLOOR:
                    cfg_reg.max_floor <= cfg_wdata[cca_pkg::FLOOR_W-1:0];
                cca_pkg::CFG_IDX_SUM_FLOOR:
                    cfg_reg.sum_floor <= cfg_wdata[cca_pkg::FLOOR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;

    cca_front #(
        .SUBFLOW_COUNT_MAX (SUBFLOW_COUNT_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cwnd     (cwnd),
        .rtt_us   (rtt_us),
        .backoff  (backoff),
        .last     (last),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    cca_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (push_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (pop_entry)
    );

    cca_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alpha     (alpha),
        .updated   (updated)
    );

endmodule

>>> tb/sv/coupled_cc_alpha_calc_test.sv
// Self-checking testbench for the coupled congestion control alpha calculator.
module coupled_cc_alpha_calc_test;
    import cca_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES   = 6000;
    localparam int RAND_PHASES   = 20;
    localparam int PHASE_ITEMS   = 100;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_UNUSED = CFG_IDX_SUM_FLOOR + 1'b1;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               updated;
    } round_result_t;

    // Tracks per-round accumulators and predicts the alpha each round closes with
    class alpha_tracker;
        bit [BACKOFF_W-1:0] backoff_limit = BACKOFF_LIMIT_RST;
        bit [RTT_W-1:0]     min_rtt       = MIN_RTT_RST;
        bit [FLOOR_W-1:0]   max_floor     = MAX_FLOOR_RST;
        bit [FLOOR_W-1:0]   sum_floor     = SUM_FLOOR_RST;

        bit [TERM_W-1:0]    max_term;
        bit [TERM_W-1:0]    rate_sum;
        bit [TOTAL_W-1:0]   window_total;
        bit                 round_aborted;
        bit [ALPHA_W-1:0]   alpha_reg;
        int unsigned        rec_count;

        round_result_t      pending_alpha[$];
        int unsigned        errors;
        int unsigned        rounds_seen;

        // floor(num/den) clipped to qbits; zero divisor gives all ones
        function bit [63:0] sat_quotient(bit [255:0] num, bit [255:0] den, int qbits);
            bit [255:0] lim;
            bit [255:0] q;
            lim = (256'd1 << qbits) - 256'd1;
            if (den == '0)
                return lim[63:0];
            q = num / den;
            if (q > lim)
                return lim[63:0];
            return q[63:0];
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_IDX_BACKOFF_LIMIT: backoff_limit = val[BACKOFF_W-1:0];
                CFG_IDX_MIN_RTT:       min_rtt       = val[RTT_W-1:0];
                CFG_IDX_MAX_FLOOR:     max_floor     = val[FLOOR_W-1:0];
                CFG_IDX_SUM_FLOOR:     sum_floor     = val[FLOOR_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted subflow record
        function void note_record(bit [CWND_W-1:0] c, bit [RTT_W-1:0] r,
                                  bit [BACKOFF_W-1:0] b, bit l);
            bit [255:0]    num;
            bit [255:0]    den;
            bit [63:0]     rate;
            bit [63:0]     term;
            bit [63:0]     quo;
            bit [64:0]     sum_ext;
            bit [32:0]     tot_ext;
            round_result_t res;
            if (rec_count == 0)
            begin
                max_term      = {32'd0, max_floor};
                rate_sum      = '0;
                window_total  = '0;
                round_aborted = 1'b0;
            end
            if (rec_count < SUBFLOW_COUNT_MAX_DEF && !round_aborted && b < backoff_limit)
            begin
                if (r < min_rtt)
                    round_aborted = 1'b1;
                else
                begin
                    num  = 256'(c) << 40;
                    den  = 256'(r);
                    rate = sat_quotient(num, den, 64);
                    term = sat_quotient(num, den * den, 64);
                    if (term > max_term)
                        max_term = term;
                    sum_ext  = {1'b0, rate_sum} + {1'b0, rate};
                    rate_sum = sum_ext[64] ? '1 : sum_ext[63:0];
                    tot_ext  = {1'b0, window_total} + 33'(c);
                    window_total = tot_ext[32] ? '1 : tot_ext[31:0];
                end
            end
            if (rec_count < SUBFLOW_COUNT_MAX_DEF)
                rec_count++;
            if (l)
            begin
                res.updated = 1'b0;
                if (!round_aborted && rate_sum >= 64'(sum_floor))
                begin
                    num = (256'(window_total) * 256'(max_term)) << ALPHA_SHIFT;
                    den = 256'(rate_sum) * 256'(rate_sum);
                    quo = sat_quotient(num, den, 32);
                    alpha_reg   = quo[31:0];
                    res.updated = 1'b1;
                end
                res.alpha = alpha_reg;
                pending_alpha = {pending_alpha, res};
                rec_count     = 0;
                round_aborted = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch round %0d: %s", rounds_seen, msg);
            errors++;
        endtask

        // One accepted result against the oldest prediction
        task check_round(logic [ALPHA_W-1:0] a, logic u);
            round_result_t exp_res;
            rounds_seen++;
            if (pending_alpha.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending, alpha=%h updated=%b", a, u));
                return;
            end
            exp_res = pending_alpha.pop_front();
            if (a !== exp_res.alpha)
                report_mismatch($sformatf("alpha %h, predicted %h", a, exp_res.alpha));
            if (u !== exp_res.updated)
                report_mismatch($sformatf("updated %b, predicted %b", u, exp_res.updated));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [CWND_W-1:0]     cwnd;
    logic [RTT_W-1:0]      rtt_us;
    logic [BACKOFF_W-1:0]  backoff;
    logic                  last;
    logic                  out_valid;
    logic                  out_stall;
    logic [ALPHA_W-1:0]    alpha;
    logic                  updated;

    alpha_tracker sb = new;
    int unsigned  burst_left;
    bit           hold_request;

    coupled_cc_alpha_calc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cwnd      (cwnd),
        .rtt_us    (rtt_us),
        .backoff   (backoff),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .alpha     (alpha),
        .updated   (updated)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Register write, single cycle, block idle
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one record, with burst gaps; returns after the transfer
    task automatic send_record(logic [CWND_W-1:0] c, logic [RTT_W-1:0] r,
                               logic [BACKOFF_W-1:0] b, logic l);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cwnd     <= c;
        rtt_us   <= r;
        backoff  <= b;
        last     <= l;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_record(c, r, b, l);
        burst_left--;
    endtask

    // Stop offering, let every pending round come out, then let the back end settle
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_alpha.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stall pattern plus one long hold-off
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_done;
        bit          stall_next;
        out_stall = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_round(alpha, updated);
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                stall_next = 1'b1;
                hold_left--;
            end
            else
            begin
                case (mode)
                    0:       stall_next = 1'b0;
                    1:       stall_next = ($urandom_range(0, 3) == 0);
                    default: stall_next = ($urandom_range(0, 3) != 0);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int                   phase;
        int                   count;
        int                   len;
        int                   k;
        int unsigned          sel;
        int unsigned          rtt_wide;
        logic [CWND_W-1:0]    c;
        logic [RTT_W-1:0]     r;
        logic [BACKOFF_W-1:0] b;
        logic [BACKOFF_W-1:0] lim;
        logic [RTT_W-1:0]     mr;
        logic [FLOOR_W-1:0]   mf;
        logic [FLOOR_W-1:0]   sf;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        cwnd         = '0;
        rtt_us       = '0;
        backoff      = '0;
        last         = 1'b0;
        burst_left   = 0;
        hold_request = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: plain single subflow, skip by backoff, cwnd zero
        send_record(24'd256, 24'd1000, 6'd0, 1'b1);
        send_record(24'hFFFFFF, 24'hFFFFFF, 6'd0, 1'b0);
        send_record(24'd0, 24'd1, 6'd3, 1'b0);
        send_record(24'd5000, 24'd20000, 6'd4, 1'b1);
        // rtt under the minimum aborts, the rest of the round is not counted
        send_record(24'd1000, 24'd0, 6'd0, 1'b0);
        send_record(24'd2000, 24'd500, 6'd0, 1'b1);
        // rate sum saturates
        send_record(24'hFFFFFF, 24'd1, 6'd0, 1'b0);
        send_record(24'hFFFFFF, 24'd1, 6'd0, 1'b1);
        // everything skipped, sum stays below its floor
        send_record(24'd100, 24'd100, 6'h3F, 1'b1);
        // leave a round open across a floor change
        send_record(24'd3000, 24'd2500, 6'd1, 1'b0);
        drain_block();

        write_reg(CFG_IDX_BACKOFF_LIMIT, 32'd63);
        write_reg(CFG_IDX_MIN_RTT, 32'd0);
        write_reg(CFG_IDX_MAX_FLOOR, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_SUM_FLOOR, 32'd0);
        write_reg(CFG_IDX_UNUSED, $urandom);
        write_reg('1, $urandom);
        // zero rtt with no minimum, closes the open round
        send_record(24'd4000, 24'd0, 6'd62, 1'b1);
        // zero sum with zero floor
        send_record(24'd0, 24'd300, 6'd0, 1'b1);
        // more records than the round can count
        for (k = 0; k < SUBFLOW_COUNT_MAX_DEF + 2; k++)
            send_record(24'($urandom_range(256, 4096)), 24'($urandom_range(100, 2000)),
                        6'd0, k == SUBFLOW_COUNT_MAX_DEF + 1);
        drain_block();

        write_reg(CFG_IDX_BACKOFF_LIMIT, 32'd1);
        write_reg(CFG_IDX_MIN_RTT, 32'hFF_FFFF);
        write_reg(CFG_IDX_MAX_FLOOR, 32'd0);
        write_reg(CFG_IDX_SUM_FLOOR, 32'hFFFF_FFFF);
        send_record(24'hFFFFFF, 24'hFFFFFE, 6'd0, 1'b1);
        send_record(24'd123, 24'hFFFFFF, 6'd0, 1'b1);
        drain_block();

        // Random phases, each with its own settings
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            case ($urandom_range(0, 4))
                0:       lim = 6'd1;
                1:       lim = 6'd63;
                default: lim = 6'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       mr = 24'd0;
                1:       mr = 24'hFFFFFF;
                default: mr = 24'($urandom_range(1, 400));
            endcase
            case ($urandom_range(0, 5))
                0:       mf = 32'd0;
                1:       mf = 32'hFFFF_FFFF;
                default: mf = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       sf = 32'd0;
                1:       sf = 32'hFFFF_FFFF;
                default: sf = $urandom;
            endcase
            write_reg(CFG_IDX_BACKOFF_LIMIT, 32'(lim));
            write_reg(CFG_IDX_MIN_RTT, 32'(mr));
            write_reg(CFG_IDX_MAX_FLOOR, mf);
            write_reg(CFG_IDX_SUM_FLOOR, sf);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_UNUSED + CFG_ADDR_W'($urandom_range(0, 11)), $urandom);
            if (phase == 3)
                hold_request = 1'b1;

            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 3)
                        c = 24'($urandom);
                    else if (sel == 3)
                        c = '0;
                    else
                        c = 24'($urandom_range(1, 64 * 256));
                    // rtt: mostly at or above the minimum, some noise
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        r = '0;
                    else if (sel < 4)
                        r = 24'($urandom);
                    else if (sel == 4)
                        r = (mr != 0) ? mr - 1'b1 : '0;
                    else
                    begin
                        rtt_wide = 32'(mr) + $urandom_range(0, 3000);
                        r = (rtt_wide > 32'hFF_FFFF) ? 24'hFFFFFF : 24'(rtt_wide);
                    end
                    if ($urandom_range(0, 3) == 0)
                        b = 6'($urandom);
                    else
                        b = 6'($urandom_range(0, lim - 1));
                    send_record(c, r, b, k == len - 1);
                    count++;
                end
            end
            drain_block();
        end

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/cca_pkg.sv
sv/cca_front.sv
sv/cca_fifo.sv
sv/cca_div.sv
sv/cca_back.sv
sv/coupled_cc_alpha_calc.sv
tb/sv/coupled_cc_alpha_calc_test.sv
